FILE: hdl/ispc_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 source packet counter package
// Shared types and constants for the frame parser, the frame queue and the
// source table engine.
// ----------------------------------------------------------------------------
package ispc_pkg;

   // Default number of entries in the source table.
   localparam int TABLE_ENTRIES_DEFAULT = 16;

   // Number of finished frames that may wait between parser and table engine.
   localparam int QUEUE_DEPTH = 4;

   // Frame layout, in byte offsets from the start of the Ethernet frame.
   localparam logic [5:0] POS_TYPE_HI   = 6'd12;
   localparam logic [5:0] POS_TYPE_LO   = 6'd13;
   localparam logic [5:0] POS_ADDR_HI   = 6'd26;
   localparam logic [5:0] POS_ADDR_LO   = 6'd29;
   localparam logic [5:0] POS_MAX       = 6'd63;
   // A frame whose last byte sits at this offset or later is long enough.
   localparam logic [5:0] POS_LAST_MIN  = 6'd33;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

   // One finished frame, as handed from the parser to the table engine.
   typedef struct packed {
      logic        counted;
      logic [31:0] source_address;
   } frame_desc_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } table_state_type;

endpackage

FILE: hdl/ispc_front.sv
// ----------------------------------------------------------------------------
// IPv4 source packet counter frame parser
// Tracks the byte offset of each frame, collects the ethertype and the IPv4
// source address, and emits one frame descriptor on the last byte.
// ----------------------------------------------------------------------------
module ispc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_accept,
   input  logic [7:0]              frame_byte,
   input  logic                    frame_last,
   output logic                    desc_push,
   output ispc_pkg::frame_desc_type desc
);
   import ispc_pkg::*;

   logic [5:0]  pos_ff,  pos_in;
   logic [15:0] type_ff, type_in;
   logic [31:0] addr_ff, addr_in;

   always_comb begin
      pos_in  = pos_ff;
      type_in = type_ff;
      addr_in = addr_ff;
      desc_push = 1'b0;
      desc.counted = 1'b0;
      desc.source_address = '0;
      if (byte_accept) begin
         if (pos_ff == POS_TYPE_HI || pos_ff == POS_TYPE_LO) begin
            type_in = {type_ff[7:0], frame_byte};
         end
         if (pos_ff >= POS_ADDR_HI && pos_ff <= POS_ADDR_LO) begin
            addr_in = {addr_ff[23:0], frame_byte};
         end
         if (frame_last) begin
            desc_push = 1'b1;
            desc.counted = (type_in == ETHERTYPE_IPV4) && (pos_ff >= POS_LAST_MIN);
            desc.source_address = desc.counted ? addr_in : '0;
            pos_in  = '0;
            type_in = '0;
            addr_in = '0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         type_ff <= '0;
         addr_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         type_ff <= type_in;
         addr_ff <= addr_in;
      end
   end

endmodule

FILE: hdl/ispc_queue.sv
// ----------------------------------------------------------------------------
// IPv4 source packet counter frame queue
// A short first-in first-out buffer of frame descriptors between the parser
// and the table engine.
// ----------------------------------------------------------------------------
module ispc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ispc_pkg::frame_desc_type push_desc,
   output logic                    full,
   input  logic                    pop,
   output logic                    not_empty,
   output ispc_pkg::frame_desc_type pop_desc
);
   import ispc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_desc_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full      = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_desc  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: hdl/ispc_table.sv
// ----------------------------------------------------------------------------
// IPv4 source packet counter table engine
// Looks up each counted source in a least-recently-used table held in a
// memory: one pass finds a hit, a free entry and the oldest entry, a second
// pass writes back the chosen entry and the aged ranks.
// ----------------------------------------------------------------------------
module ispc_table #(
   parameter int TABLE_ENTRIES = ispc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    desc_valid,
   input  ispc_pkg::frame_desc_type desc,
   output logic                    desc_pop,
   output logic                    clearing,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_counted,
   output logic [31:0]             rsp_source_address,
   output logic [31:0]             rsp_packet_count,
   output logic                    rsp_replaced_entry
);
   import ispc_pkg::*;

   localparam int AW     = $clog2(TABLE_ENTRIES);
   localparam int CW     = $clog2(TABLE_ENTRIES + 1);
   localparam int RANK_W = AW;

   typedef struct packed {
      logic              valid;
      logic [RANK_W-1:0] rank;
      logic [31:0]       key;
      logic [31:0]       count;
   } entry_type;

   entry_type entry_mem [TABLE_ENTRIES];

   table_state_type state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            rd_vld_ff;
   logic [AW-1:0]   rd_idx_ff;
   entry_type       rd_data_ff;

   logic [31:0]       key_ff, key_in;
   logic              hit_ff, hit_in;
   logic [AW-1:0]     hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0] hit_rank_ff, hit_rank_in;
   logic [31:0]       hit_count_ff, hit_count_in;
   logic              free_ff, free_in;
   logic [AW-1:0]     free_idx_ff, free_idx_in;
   logic [AW-1:0]     old_idx_ff, old_idx_in;
   logic [RANK_W-1:0] old_rank_ff, old_rank_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_counted_ff, rsp_counted_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [31:0] rsp_count_ff, rsp_count_in;
   logic        rsp_replaced_ff, rsp_replaced_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   logic [AW-1:0] chosen;
   logic          evict;
   logic [31:0]   new_count;
   logic          last_read;

   assign chosen    = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : old_idx_ff);
   assign evict     = !hit_ff && !free_ff;
   assign new_count = hit_ff ? hit_count_ff + 32'd1 : 32'd1;
   assign last_read = rd_vld_ff && (rd_idx_ff == AW'(TABLE_ENTRIES - 1));

   assign clearing           = (state_ff == ST_CLEAR);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_counted        = rsp_counted_ff;
   assign rsp_source_address = rsp_addr_ff;
   assign rsp_packet_count   = rsp_count_ff;
   assign rsp_replaced_entry = rsp_replaced_ff;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      key_in          = key_ff;
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      hit_rank_in     = hit_rank_ff;
      hit_count_in    = hit_count_ff;
      free_in         = free_ff;
      free_idx_in     = free_idx_ff;
      old_idx_in      = old_idx_ff;
      old_rank_in     = old_rank_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_counted_in  = rsp_counted_ff;
      rsp_addr_in     = rsp_addr_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_replaced_in = rsp_replaced_ff;
      mem_we          = 1'b0;
      mem_waddr       = rd_idx_ff;
      mem_wdata       = rd_data_ff;
      rd_en           = 1'b0;
      rd_addr         = cnt_ff[AW-1:0];
      desc_pop        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // Zero one entry per cycle so every entry starts invalid, rank zero.
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            mem_wdata = '0;
            if (cnt_ff == CW'(TABLE_ENTRIES - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            if (desc_valid && !rsp_valid_ff) begin
               desc_pop = 1'b1;
               if (desc.counted) begin
                  key_in      = desc.source_address;
                  hit_in      = 1'b0;
                  free_in     = 1'b0;
                  old_idx_in  = '0;
                  old_rank_in = '0;
                  cnt_in      = '0;
                  state_in    = ST_SCAN;
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_counted_in  = 1'b0;
                  rsp_addr_in     = '0;
                  rsp_count_in    = '0;
                  rsp_replaced_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff != CW'(TABLE_ENTRIES)) begin
               rd_en  = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (rd_data_ff.valid && rd_data_ff.key == key_ff && !hit_ff) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_rank_in  = rd_data_ff.rank;
                  hit_count_in = rd_data_ff.count;
               end
               if (!rd_data_ff.valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               // Strict compare keeps the lowest index among equal ranks.
               if (rd_data_ff.rank > old_rank_ff) begin
                  old_idx_in  = rd_idx_ff;
                  old_rank_in = rd_data_ff.rank;
               end
            end
            if (last_read) begin
               cnt_in   = '0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (cnt_ff != CW'(TABLE_ENTRIES)) begin
               rd_en  = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (rd_idx_ff == chosen) begin
                  mem_we          = 1'b1;
                  mem_wdata.valid = 1'b1;
                  mem_wdata.rank  = '0;
                  mem_wdata.key   = key_ff;
                  mem_wdata.count = new_count;
               end else if (rd_data_ff.valid && (!hit_ff || rd_data_ff.rank < hit_rank_ff)) begin
                  mem_we         = 1'b1;
                  mem_wdata.rank = rd_data_ff.rank + RANK_W'(1);
               end
            end
            if (last_read) begin
               rsp_valid_in    = 1'b1;
               rsp_counted_in  = 1'b1;
               rsp_addr_in     = key_ff;
               rsp_count_in    = new_count;
               rsp_replaced_in = evict;
               cnt_in          = '0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            cnt_in   = '0;
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      hit_idx_ff      <= hit_idx_in;
      hit_rank_ff     <= hit_rank_in;
      hit_count_ff    <= hit_count_in;
      free_idx_ff     <= free_idx_in;
      old_idx_ff      <= old_idx_in;
      old_rank_ff     <= old_rank_in;
      rd_idx_ff       <= rd_addr;
      rsp_counted_ff  <= rsp_counted_in;
      rsp_addr_ff     <= rsp_addr_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_replaced_ff <= rsp_replaced_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_en;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A frame leaves the queue only when the engine is idle and the output
   // register is free.
   assert property (@(posedge clock) disable iff (reset)
      desc_pop |-> (state_ff == ST_IDLE) && !rsp_valid_ff)
      else $error("frame taken while the table engine was busy");

   // A frame that was not counted carries no count and no eviction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_counted_ff |-> rsp_count_ff == '0 && !rsp_replaced_ff)
      else $error("uncounted frame with a count or eviction");

   // An eviction always inserts a fresh source with a count of one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_replaced_ff |-> rsp_count_ff == 32'd1)
      else $error("eviction without a fresh count");

   // The write-back pass never writes the entry being read in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      mem_we && rd_en |-> mem_waddr != rd_addr)
      else $error("table write collides with table read");

endmodule

FILE: hdl/ipv4_source_packet_counter_unit.sv
// ----------------------------------------------------------------------------
// IPv4 source packet counter unit
// Counts IPv4 frames per source address in a least-recently-used table.
// ----------------------------------------------------------------------------
// The unit takes one Ethernet frame byte per cycle on the req_ channel
// while req_ready is high and gives one item on the rsp_ channel for every
// frame. A frame is counted when its ethertype (bytes 12 and 13) is 0x0800
// and it holds at least 34 bytes; the source address is taken from bytes
// 26 to 29. A counted source that is already in the table has its 32-bit
// count incremented (it wraps) and becomes the most recent entry; a new
// source takes the lowest free entry, or else replaces the least recently
// used one, which is then flagged in rsp_replaced_entry. Frames that are not
// counted report all zeros. Frame bytes are accepted at one per cycle;
// finished frames wait in a four-deep queue for the table engine. The
// engine walks its table memory twice per counted frame, one entry per
// cycle on a single read port, and does not walk it for an uncounted frame.
// In either case the engine takes the next frame only once the previous
// item has left its output register. The queue fills, and req_ready drops,
// when frames end faster than the engine retires them, as with runs of
// minimum-length counted frames or of very short frames, or when rsp_ready
// is held low. After reset the engine clears its table, during which
// req_ready is low.
module ipv4_source_packet_counter_unit #(
   parameter int TABLE_ENTRIES = ispc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_counted,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_packet_count,
   output logic        rsp_replaced_entry
);
   import ispc_pkg::*;

   logic           byte_accept;
   logic           desc_push;
   frame_desc_type push_desc;
   logic           queue_full;
   logic           desc_pop;
   logic           desc_valid;
   frame_desc_type pop_desc;
   logic           clearing;

   // Bytes are refused while the table is being cleared, and whenever a
   // finished frame might find the queue full.
   assign req_ready   = !queue_full && !clearing;
   assign byte_accept = req_valid && req_ready;

   ispc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_accept(byte_accept),
      .frame_byte (req_frame_byte),
      .frame_last (req_frame_last),
      .desc_push  (desc_push),
      .desc       (push_desc)
   );

   ispc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (desc_push),
      .push_desc(push_desc),
      .full     (queue_full),
      .pop      (desc_pop),
      .not_empty(desc_valid),
      .pop_desc (pop_desc)
   );

   ispc_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_table (
      .clock             (clock),
      .reset             (reset),
      .desc_valid        (desc_valid),
      .desc              (pop_desc),
      .desc_pop          (desc_pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_counted       (rsp_counted),
      .rsp_source_address(rsp_source_address),
      .rsp_packet_count  (rsp_packet_count),
      .rsp_replaced_entry(rsp_replaced_entry)
   );

endmodule
